// ===== src/clt_pkg.sv =====
// Shared constants, item kinds and the input clamp for the trilinear colour LUT.
// No dependencies; every other file but clt_fifo imports this package.
package clt_pkg;

   localparam int IDX_W       = 15;
   localparam int BYTE_W      = 8;
   localparam int ENTRY_W     = 24;
   localparam int IN_W        = 18;
   localparam int CLAMP_W     = 17;
   localparam int FRAC_W      = 16;
   localparam int CHAN_W      = 24;
   localparam int RSP_W       = 3 * CHAN_W + 1;
   localparam int QUEUE_DEPTH = 8;
   localparam int CNT_W       = 4;
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_W     = 22;
   localparam int PROD_W      = IDX_W + RECIP_W;

   // queue entry layout between front and back, lowest bit first
   localparam int Q_KIND  = 0;
   localparam int Q_FR    = 2;
   localparam int Q_FG    = Q_FR + FRAC_W;
   localparam int Q_FB    = Q_FG + FRAC_W;
   localparam int Q_PAR   = Q_FB + FRAC_W;
   localparam int Q_WDATA = Q_PAR + 3;
   localparam int Q_WBANK = Q_WDATA + ENTRY_W;
   localparam int Q_ADDR  = Q_WBANK + 3;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [CLAMP_W-1:0] ONE_FIX = 17'h10000;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_FAIL   = 2'd2,
      KIND_SKIP   = 2'd3
   } kind_type;

   // clamp a signed 2.16 channel to [0, 1.0]
   function automatic logic [CLAMP_W-1:0] clamp_unit(input logic [IN_W-1:0] raw);
      logic [CLAMP_W-1:0] v;
      v = raw[CLAMP_W-1:0];
      if (raw[IN_W-1]) begin
         return '0;
      end else if (v > ONE_FIX) begin
         return ONE_FIX;
      end
      return v;
   endfunction

endpackage

// ===== src/colour_lut_trilinear.sv =====
// Top level of the trilinear colour LUT: front end, decoupling queue, back end
// and result FIFO. Uses clt_pkg, clt_front, clt_fifo and clt_back.
//
//  channel  | direction | handshake              | contents
//  req_     | in        | tvalid/tready          | tuser cmd, tdata entry and lookup fields
//  rsp_     | out       | tvalid/tready          | tuser not_ready, tdata blended colour
//  csr_     | in        | csr_wr_en              | csr_wr_data = lut_ready
//
// One transaction per clock sustained while rsp_tready stays high, writes and lookups alike.
// Path of an item: three front stages, the queue, the bank read and
// three blend stages; the eight parity banks give all corners in one read.
// Reset clears control state only; table contents stay undefined until written.
// Stalls on rsp_ fill the result FIFO, then the queue, then drop req_tready.
module colour_lut_trilinear #(
   parameter int GRID_SIZE = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,     // cmd
   input  logic [95:0]  req_tdata,     // entry_index, entry_red, entry_green, entry_blue,
                                       // red_in, green_in, blue_in, zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,     // not_ready
   output logic [71:0]  rsp_tdata,     // red_out, green_out, blue_out
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);
   import clt_pkg::*;

   localparam int HB         = (GRID_SIZE + 1) / 2;
   localparam int BANK_DEPTH = HB * HB * HB;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int QW         = Q_ADDR + 8 * AW;

   logic                lut_ready_ff, lut_ready_in;
   logic [IN_W-1:0]     chan [3];
   logic                q_push, q_pop;
   logic [QW-1:0]       q_in_data, q_out_data;
   logic [CNT_W-1:0]    q_count, o_count;
   logic                o_push, o_pop;
   logic [RSP_W-1:0]    o_in_data, o_out_data;

   assign lut_ready_in = csr_wr_en ? csr_wr_data : lut_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lut_ready_ff <= 1'b0;
      end else begin
         lut_ready_ff <= lut_ready_in;
      end
   end

   assign chan[0] = req_tdata[56:39];
   assign chan[1] = req_tdata[74:57];
   assign chan[2] = req_tdata[92:75];

   clt_front #(.GRID_SIZE(GRID_SIZE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_index  (req_tdata[14:0]),
      .in_entry  (req_tdata[38:15]),
      .in_chan   (chan),
      .lut_ready (lut_ready_ff),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_data    (q_in_data)
   );

   clt_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .count     (q_count)
   );

   clt_back #(.GRID_SIZE(GRID_SIZE)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_count   (q_count),
      .q_data    (q_out_data),
      .q_pop     (q_pop),
      .out_count (o_count),
      .out_push  (o_push),
      .out_data  (o_in_data)
   );

   clt_fifo #(.WIDTH(RSP_W), .DEPTH(QUEUE_DEPTH)) u_result (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_in_data),
      .pop       (o_pop),
      .pop_data  (o_out_data),
      .count     (o_count)
   );

   assign rsp_tvalid = (o_count != '0);
   assign o_pop      = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = o_out_data[3*CHAN_W-1:0];
   assign rsp_tuser  = o_out_data[3*CHAN_W];
endmodule

// ===== src/clt_fifo.sv =====
// Small synchronous FIFO with an occupancy count; callers never push when full.
// Depends on nothing but its parameters.
module clt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH):0]     count
);
   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem[rd_ptr_ff];
   assign count    = count_ff;
endmodule

// ===== src/clt_front.sv =====
// Front end: classifies transactions, splits write indices into bank and address,
// clamps and scales lookup channels, and forms the eight bank addresses. Uses clt_pkg.
module clt_front #(
   parameter int GRID_SIZE = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               in_cmd,
   input  logic [clt_pkg::IDX_W-1:0]          in_index,
   input  logic [clt_pkg::ENTRY_W-1:0]        in_entry,
   input  logic [clt_pkg::IN_W-1:0]           in_chan [3],
   input  logic                               lut_ready,
   input  logic [clt_pkg::CNT_W-1:0]          q_count,
   output logic                               q_push,
   output logic [clt_pkg::Q_ADDR+8*((((GRID_SIZE+1)/2)**3 > 1) ?
                 $clog2(((GRID_SIZE+1)/2)**3) : 1)-1:0] q_data
);
   import clt_pkg::*;

   localparam int CW          = $clog2(GRID_SIZE);
   localparam int HB          = (GRID_SIZE + 1) / 2;
   localparam int BANK_DEPTH  = HB * HB * HB;
   localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int QW          = Q_ADDR + 8 * AW;
   localparam int SW          = CLAMP_W + CW;
   localparam int TABLE_DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + GRID_SIZE - 1) / GRID_SIZE);
   localparam logic [CW-1:0] TOP = CW'(GRID_SIZE - 1);

   function automatic logic [AW-1:0] bank_addr(input logic [CW-1:0] cr,
                                                input logic [CW-1:0] cg,
                                                input logic [CW-1:0] cb);
      logic [19:0] t;
      t = (20'(cb >> 1) * 20'(HB) + 20'(cg >> 1)) * 20'(HB) + 20'(cr >> 1);
      return t[AW-1:0];
   endfunction

   // stage A
   logic                a_valid_ff;
   kind_type            a_kind_ff, a_kind_in;
   logic [ENTRY_W-1:0]  a_wdata_ff;
   logic [IDX_W-1:0]    a_idx_ff, a_q1_ff, a_q1_in;
   logic [SW-1:0]       a_s_ff [3];
   logic [SW-1:0]       a_s_in [3];
   logic [PROD_W-1:0]   prod1;

   // stage B
   logic                b_valid_ff;
   kind_type            b_kind_ff;
   logic [ENTRY_W-1:0]  b_wdata_ff;
   logic [CW-1:0]       b_r_ff, b_r_in;
   logic [IDX_W-1:0]    b_q1_ff, b_q2_ff, b_q2_in, r_full;
   logic [PROD_W-1:0]   prod2;
   logic [CW-1:0]       b_lo_ff [3];
   logic [CW-1:0]       b_hi_ff [3];
   logic [FRAC_W-1:0]   b_f_ff [3];
   logic [CW-1:0]       b_lo_in [3];
   logic [CW-1:0]       b_hi_in [3];
   logic [FRAC_W-1:0]   b_f_in [3];
   logic [SW-CLAMP_W+1-1:0] cell_no [3];

   // stage C
   logic                c_valid_ff;
   logic [QW-1:0]       c_data_ff, c_data_in;
   logic [IDX_W-1:0]    g_full;
   logic [CW-1:0]       wg, wb, cr, cg, cb;

   logic                accept;

   assign in_ready = ({1'b0, q_count} + (CNT_W+1)'(a_valid_ff) + (CNT_W+1)'(b_valid_ff)
                      + (CNT_W+1)'(c_valid_ff)) < (CNT_W+1)'(QUEUE_DEPTH);
   assign accept   = in_valid && in_ready;

   always_comb begin
      prod1   = PROD_W'(in_index) * PROD_W'(RECIP);
      a_q1_in = prod1[PROD_W-1:RECIP_SHIFT];
      if (in_cmd == CMD_WRITE) begin
         a_kind_in = (32'(in_index) < TABLE_DEPTH) ? KIND_WRITE : KIND_SKIP;
      end else begin
         a_kind_in = lut_ready ? KIND_LOOKUP : KIND_FAIL;
      end
      for (int c = 0; c < 3; c++) begin
         a_s_in[c] = SW'(clamp_unit(in_chan[c])) * SW'(GRID_SIZE - 1);
      end
   end

   always_comb begin
      r_full  = a_idx_ff - IDX_W'(a_q1_ff * IDX_W'(GRID_SIZE));
      b_r_in  = r_full[CW-1:0];
      prod2   = PROD_W'(a_q1_ff) * PROD_W'(RECIP);
      b_q2_in = prod2[PROD_W-1:RECIP_SHIFT];
      for (int c = 0; c < 3; c++) begin
         cell_no[c] = a_s_ff[c][SW-1:FRAC_W];
         if (cell_no[c] >= (SW-FRAC_W)'(GRID_SIZE - 1)) begin
            b_lo_in[c] = TOP;
            b_hi_in[c] = TOP;
            b_f_in[c]  = '0;
         end else begin
            b_lo_in[c] = cell_no[c][CW-1:0];
            b_hi_in[c] = cell_no[c][CW-1:0] + 1'b1;
            b_f_in[c]  = a_s_ff[c][FRAC_W-1:0];
         end
      end
   end

   always_comb begin
      g_full    = b_q1_ff - IDX_W'(b_q2_ff * IDX_W'(GRID_SIZE));
      wg        = g_full[CW-1:0];
      wb        = b_q2_ff[CW-1:0];
      c_data_in = '0;
      c_data_in[Q_KIND +: 2]       = b_kind_ff;
      c_data_in[Q_FR +: FRAC_W]    = b_f_ff[0];
      c_data_in[Q_FG +: FRAC_W]    = b_f_ff[1];
      c_data_in[Q_FB +: FRAC_W]    = b_f_ff[2];
      c_data_in[Q_PAR +: 3]        = {b_lo_ff[2][0], b_lo_ff[1][0], b_lo_ff[0][0]};
      c_data_in[Q_WDATA +: ENTRY_W] = b_wdata_ff;
      c_data_in[Q_WBANK +: 3]      = {wb[0], wg[0], b_r_ff[0]};
      cr = '0;
      cg = '0;
      cb = '0;
      if (b_kind_ff == KIND_WRITE) begin
         c_data_in[Q_ADDR +: AW] = bank_addr(b_r_ff, wg, wb);
      end else begin
         // each bank holds one parity class, so it supplies the corner of that parity
         for (int p = 0; p < 8; p++) begin
            cr = (p[0] == b_lo_ff[0][0]) ? b_lo_ff[0] : b_hi_ff[0];
            cg = (p[1] == b_lo_ff[1][0]) ? b_lo_ff[1] : b_hi_ff[1];
            cb = (p[2] == b_lo_ff[2][0]) ? b_lo_ff[2] : b_hi_ff[2];
            c_data_in[Q_ADDR + p*AW +: AW] = bank_addr(cr, cg, cb);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_kind_ff  <= a_kind_in;
      a_wdata_ff <= in_entry;
      a_idx_ff   <= in_index;
      a_q1_ff    <= a_q1_in;
      a_s_ff     <= a_s_in;
      b_kind_ff  <= a_kind_ff;
      b_wdata_ff <= a_wdata_ff;
      b_r_ff     <= b_r_in;
      b_q1_ff    <= a_q1_ff;
      b_q2_ff    <= b_q2_in;
      b_lo_ff    <= b_lo_in;
      b_hi_ff    <= b_hi_in;
      b_f_ff     <= b_f_in;
      c_data_ff  <= c_data_in;
   end

   assign q_push = c_valid_ff;
   assign q_data = c_data_ff;
endmodule

// ===== src/clt_back.sv =====
// Back end: eight parity banks of the table, corner reordering and three
// separable interpolation stages. Uses clt_pkg.
module clt_back #(
   parameter int GRID_SIZE = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [clt_pkg::CNT_W-1:0]          q_count,
   input  logic [clt_pkg::Q_ADDR+8*((((GRID_SIZE+1)/2)**3 > 1) ?
                 $clog2(((GRID_SIZE+1)/2)**3) : 1)-1:0] q_data,
   output logic                               q_pop,
   input  logic [clt_pkg::CNT_W-1:0]          out_count,
   output logic                               out_push,
   output logic [clt_pkg::RSP_W-1:0]          out_data
);
   import clt_pkg::*;

   localparam int HB         = (GRID_SIZE + 1) / 2;
   localparam int BANK_DEPTH = HB * HB * HB;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int XW         = 24;
   localparam int YW         = 40;
   localparam int ZW         = 56;

   kind_type            q_kind;
   logic [AW-1:0]       q_addr [8];
   logic [ENTRY_W-1:0]  rd_data [8];
   logic                wr_en, rd_en;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   kind_type            s1_kind_ff, s2_kind_ff, s3_kind_ff;
   logic [FRAC_W-1:0]   s1_f_ff [3];
   logic [2:0]          s1_par_ff;
   logic [FRAC_W-1:0]   s2_fg_ff, s2_fb_ff, s3_fb_ff;
   logic [XW-1:0]       s2_x_ff [4][3];
   logic [XW-1:0]       s2_x_in [4][3];
   logic [YW-1:0]       s3_y_ff [2][3];
   logic [YW-1:0]       s3_y_in [2][3];
   logic [ZW-1:0]       z [3];
   logic [BYTE_W-1:0]   e0, e1;
   logic [2:0]          b0, b1;

   assign q_kind = kind_type'(q_data[Q_KIND +: 2]);
   assign q_pop  = (q_count != '0) &&
                   (({1'b0, out_count} + (CNT_W+1)'(s1_valid_ff) + (CNT_W+1)'(s2_valid_ff)
                     + (CNT_W+1)'(s3_valid_ff)) < (CNT_W+1)'(QUEUE_DEPTH));
   assign wr_en  = q_pop && (q_kind == KIND_WRITE);
   assign rd_en  = q_pop && (q_kind == KIND_LOOKUP);

   for (genvar p = 0; p < 8; p++) begin : g_bank
      logic [ENTRY_W-1:0] mem [BANK_DEPTH];
      logic [ENTRY_W-1:0] rd_ff;
      assign q_addr[p] = q_data[Q_ADDR + p*AW +: AW];
      always_ff @(posedge clock) begin
         if (wr_en && (q_data[Q_WBANK +: 3] == 3'(p))) begin
            mem[q_addr[0]] <= q_data[Q_WDATA +: ENTRY_W];
         end
         if (rd_en) begin
            rd_ff <= mem[q_addr[p]];
         end
      end
      assign rd_data[p] = rd_ff;
   end

   // blend along red: corner (i,j,k) sits in the bank of parity lo ^ (i,j,k)
   always_comb begin
      e0 = '0;
      e1 = '0;
      b0 = '0;
      b1 = '0;
      for (int jk = 0; jk < 4; jk++) begin
         for (int ch = 0; ch < 3; ch++) begin
            b0 = s1_par_ff ^ {jk[1], jk[0], 1'b0};
            b1 = s1_par_ff ^ {jk[1], jk[0], 1'b1};
            e0 = rd_data[b0][BYTE_W*ch +: BYTE_W];
            e1 = rd_data[b1][BYTE_W*ch +: BYTE_W];
            if (s1_f_ff[0] == '0) begin
               s2_x_in[jk][ch] = {e0, 16'h0};
            end else begin
               s2_x_in[jk][ch] = XW'({e0, 16'h0}) +
                                 (XW'(e1) - XW'(e0)) * XW'(s1_f_ff[0]);
            end
         end
      end
   end

   // blend along green, then blue; modular arithmetic, the true result always fits
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         for (int ch = 0; ch < 3; ch++) begin
            if (s2_fg_ff == '0) begin
               s3_y_in[k][ch] = YW'({s2_x_ff[2*k][ch], 16'h0});
            end else begin
               s3_y_in[k][ch] = YW'({s2_x_ff[2*k][ch], 16'h0}) +
                                (YW'(s2_x_ff[2*k+1][ch]) - YW'(s2_x_ff[2*k][ch]))
                                * YW'(s2_fg_ff);
            end
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         if (s3_fb_ff == '0) begin
            z[ch] = ZW'({s3_y_ff[0][ch], 16'h0});
         end else begin
            z[ch] = ZW'({s3_y_ff[0][ch], 16'h0}) +
                    (ZW'(s3_y_ff[1][ch]) - ZW'(s3_y_ff[0][ch])) * ZW'(s3_fb_ff);
         end
      end
   end

   always_comb begin
      out_push = s3_valid_ff && ((s3_kind_ff == KIND_LOOKUP) || (s3_kind_ff == KIND_FAIL));
      case (s3_kind_ff)
         KIND_LOOKUP: begin
            out_data = {1'b0, z[2][ZW-1 -: CHAN_W], z[1][ZW-1 -: CHAN_W],
                        z[0][ZW-1 -: CHAN_W]};
         end
         KIND_FAIL: begin
            out_data = {1'b1, {(3*CHAN_W){1'b0}}};
         end
         default: begin
            out_data = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= q_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= q_kind;
      s1_f_ff[0] <= q_data[Q_FR +: FRAC_W];
      s1_f_ff[1] <= q_data[Q_FG +: FRAC_W];
      s1_f_ff[2] <= q_data[Q_FB +: FRAC_W];
      s1_par_ff  <= q_data[Q_PAR +: 3];
      s2_kind_ff <= s1_kind_ff;
      s2_fg_ff   <= s1_f_ff[1];
      s2_fb_ff   <= s1_f_ff[2];
      s2_x_ff    <= s2_x_in;
      s3_kind_ff <= s2_kind_ff;
      s3_fb_ff   <= s2_fb_ff;
      s3_y_ff    <= s3_y_in;
   end
endmodule

// ===== test/colour_lut_trilinear_checker.sv =====
`timescale 1ns / 1ps
// Checker for the trilinear colour LUT: watches req_ and rsp_ channels, predicts
// each lookup result with its own table copy, and counts mismatches. Uses clt_pkg.
module colour_lut_trilinear_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        rsp_tuser,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          fail_count,
   output int          pending
);
   import clt_pkg::*;

   typedef struct packed {
      logic        not_ready;
      logic [23:0] blue;
      logic [23:0] green;
      logic [23:0] red;
   } colour_type;

   logic [23:0] grade_table [0:32767];
   logic        table_loaded;
   colour_type  expected_colours[$];

   // clamp, scale by 31, split into cell and fraction
   function automatic void split_axis(input logic [17:0] raw, output int lo, output int hi,
                                      output longint frac);
      longint v, s;
      if (raw[17]) v = 0;
      else if (raw[16:0] > 17'h10000) v = 65536;
      else v = raw[16:0];
      s = v * 31;
      lo = int'(s >> 16);
      frac = s & 16'hFFFF;
      if (lo >= 31) begin
         lo = 31;
         frac = 0;
      end
      hi = (lo + 1 > 31) ? lo : lo + 1;
   endfunction

   function automatic colour_type blend_colour(input logic [95:0] d);
      int rc[2], gc[2], bc[2];
      longint rf, gf, bf, w;
      longint rw[2], gw[2], bw[2];
      longint acc[3];
      logic [23:0] e;
      colour_type c;
      split_axis(d[56:39], rc[0], rc[1], rf);
      split_axis(d[74:57], gc[0], gc[1], gf);
      split_axis(d[92:75], bc[0], bc[1], bf);
      rw[0] = 65536 - rf; rw[1] = rf;
      gw[0] = 65536 - gf; gw[1] = gf;
      bw[0] = 65536 - bf; bw[1] = bf;
      acc = '{0, 0, 0};
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) begin
               w = rw[i] * gw[j] * bw[k];
               e = grade_table[15'(bc[k] * 1024 + gc[j] * 32 + rc[i])];
               for (int ch = 0; ch < 3; ch++)
                  acc[ch] += w * longint'(e[8*ch +: 8]);
            end
      c.red = 24'(acc[0] >> 32);
      c.green = 24'(acc[1] >> 32);
      c.blue = 24'(acc[2] >> 32);
      c.not_ready = 1'b0;
      return c;
   endfunction

   assign pending = expected_colours.size();

   always @(posedge clock) begin
      colour_type want, got;
      if (reset) begin
         table_loaded <= 1'b0;
         fail_count <= 0;
         expected_colours.delete();
      end else begin
         if (csr_wr_en) table_loaded <= csr_wr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_WRITE) begin
               grade_table[req_tdata[14:0]] = req_tdata[38:15];
            end else if (!table_loaded) begin
               want = '0;
               want.not_ready = 1'b1;
               expected_colours = {expected_colours, want};
            end else begin
               expected_colours = {expected_colours, blend_colour(req_tdata)};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_colours.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_colours.pop_front();
               if (got !== want) begin
                  $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== test/colour_lut_trilinear_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the trilinear colour LUT: writes, lookups, register
// phases and random stalls. Uses clt_pkg, colour_lut_trilinear and its checker.
module colour_lut_trilinear_tb;
   import clt_pkg::*;

   localparam int WATCHDOG = 20000;
   // cells loaded on each axis; lookups only land between these
   localparam int AXIS_CELL [6] = '{0, 1, 2, 3, 30, 31};

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [95:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tuser;
   logic [71:0] rsp_tdata;
   logic        csr_wr_en, csr_wr_data;
   int          fail_count, pending, quiet_cycles;
   bit          req_idle_on, rsp_idle_on;

   colour_lut_trilinear #(.GRID_SIZE(32)) dut (.*);
   colour_lut_trilinear_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stall bursts
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            rsp_tready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   task automatic send_item(input logic cmd, input logic [95:0] data);
      int n;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 10);
         req_tvalid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_entry(input logic [14:0] idx, input logic [23:0] rgb);
      send_item(CMD_WRITE, {57'd0, rgb, idx});
   endtask

   task automatic look_up(input logic [17:0] r, input logic [17:0] g, input logic [17:0] b);
      send_item(CMD_LOOKUP, {3'd0, b, g, r, $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0,
                             15'($urandom)});
   endtask

   task automatic drain_and_set(input logic ready);
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = ready;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // channel values whose cells stay within the loaded low and high cells
   function automatic logic [17:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 18'h20000;
         1: return 18'h1FFFF;
         2: return 18'h10000;
         3: return 18'h0;
         4: return {1'b1, 17'($urandom)};
         5: return 18'($urandom_range(65537, 131071));
         6: return 18'($urandom_range(63423, 65536));
         default: return 18'($urandom_range(0, 6342));
      endcase
   endfunction

   initial begin
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      reset = 1'b1;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // lookups while the table is not marked ready
      look_up(18'h0, 18'h10000, 18'h20000);
      look_up(18'h1FFFF, 18'h3FFFF, 18'h8000);
      // load the low and high cells of every axis, then pin the two extreme corners
      for (int i = 0; i < 6; i++)
         for (int j = 0; j < 6; j++)
            for (int k = 0; k < 6; k++)
               write_entry(15'(AXIS_CELL[k] * 1024 + AXIS_CELL[j] * 32 + AXIS_CELL[i]),
                           24'($urandom));
      write_entry(15'd0, 24'h000000);
      write_entry(15'd32767, 24'hFFFFFF);
      drain_and_set(1'b1);

      // directed lookups: clamps, top edge, fractions in the low and high cells
      look_up(18'h0, 18'h0, 18'h0);
      look_up(18'h10000, 18'h10000, 18'h10000);
      look_up(18'h20000, 18'h3FFFF, 18'h1FFFF);
      look_up(18'h1FFFF, 18'h10001, 18'h0FFFF);
      look_up(18'h00800, 18'h01000, 18'h0F800);
      look_up(18'h0FBE0, 18'h00843, 18'h3FFFF);
      look_up(18'h2AAAA, 18'h15555, 18'h018AA);

      // sender holds off until everything is out
      while (pending != 0) @(negedge clock);

      for (int i = 0; i < 250; i++) begin
         if ($urandom_range(0, 3) == 0)
            write_entry(15'($urandom), 24'($urandom));
         else
            look_up(rand_chan(), rand_chan(), rand_chan());
      end

      drain_and_set(1'b0);
      for (int i = 0; i < 20; i++)
         look_up(rand_chan(), rand_chan(), rand_chan());
      drain_and_set(1'b1);

      // final stretch at full rate
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < 150; i++)
         look_up(rand_chan(), rand_chan(), rand_chan());

      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
